### rtl/core/msk_pkg.sv
// Shared types and constants for the merge sort keys unit.
// No dependencies; imported by every module of the block.
package msk_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int KEY_BITS  = 32;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic shl;
  } cell_cmd_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

endpackage

### rtl/core/msk_cell.sv
// One cell of the sorting chain: holds a single key and trades it with neighbors.
// Depends on msk_pkg for the key and command types.
module msk_cell (
  input  logic              clk,
  input  msk_pkg::cell_cmd_t cmd,
  input  msk_pkg::key_t     new_key,
  input  logic              occ,
  input  logic              prev_keep,
  input  msk_pkg::key_t     prev_key,
  input  msk_pkg::key_t     next_key,
  output logic              keep,
  output msk_pkg::key_t     key
);
  import msk_pkg::*;

  key_t key_r;
  key_t key_nxt;

  // An occupied cell whose key is not above the new key stays put, so equal
  // keys keep their arrival order.
  assign keep = occ && (key_r <= new_key);
  assign key  = key_r;

  always_comb begin
    key_nxt = key_r;
    if (cmd.ins) begin
      if (keep) begin
        key_nxt = key_r;
      end else if (prev_keep) begin
        key_nxt = new_key;
      end else begin
        key_nxt = prev_key;
      end
    end else if (cmd.shl) begin
      key_nxt = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

### rtl/core/msk_chain.sv
// Row of MAX_ITEMS sorting cells kept in ascending order from cell zero.
// Depends on msk_pkg and msk_cell.
module msk_chain (
  input  logic               clk,
  input  msk_pkg::cell_cmd_t cmd,
  input  msk_pkg::key_t      new_key,
  input  msk_pkg::cnt_t      count,
  output msk_pkg::key_t      head_key
);
  import msk_pkg::*;

  key_t                 cell_key [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] cell_keep;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    localparam cnt_t IDX = CNT_W'(i);
    logic occ;
    logic prev_keep;
    key_t prev_key;
    key_t next_key;

    assign occ = IDX < count;

    if (i == 0) begin : g_first
      assign prev_keep = 1'b1;
      assign prev_key  = '0;
    end else begin : g_mid
      assign prev_keep = cell_keep[i-1];
      assign prev_key  = cell_key[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_end
      assign next_key = '0;
    end else begin : g_inner
      assign next_key = cell_key[i+1];
    end

    msk_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .new_key   (new_key),
      .occ       (occ),
      .prev_keep (prev_keep),
      .prev_key  (prev_key),
      .next_key  (next_key),
      .keep      (cell_keep[i]),
      .key       (cell_key[i])
    );
  end

  assign head_key = cell_key[0];

endmodule

### rtl/core/merge_sort_keys_unit.sv
// Top level of the merge sort keys unit: load control, drain control, output register.
// Depends on msk_pkg and msk_chain.
//
// Usage:
//   Keys arrive on the in_ channel (in_key, in_last) with valid/ready. Each
//   accepted key is inserted into a chain of 64 cells, so the chain stays
//   in ascending order at all times. Keys beyond 64 in one set are dropped
//   and every result of that set carries out_overflow.
//   The transfer with in_last = 1 ends the set. From the next cycle the
//   chain shifts toward cell zero and one key per cycle moves into the
//   output register while the receiver keeps out_ready high; the first result
//   becomes valid once the state has turned to drain and the head key has
//   been registered. out_last_out marks the final key of the set.
//   Loading and emitting of a set do not overlap.
//   While the set drains in_ready is low; loading of the next set starts
//   in the cycle after the final result enters the output register.
//   When the receiver stalls the output register holds its result and the
//   chain stops shifting until it is taken.
//   Reset (rst_n low, synchronous) empties the set, clears the overflow
//   mark and the output valid flag; cell contents and output data need no reset.
module merge_sort_keys_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  msk_pkg::key_t in_key,
  input  logic          in_last,
  output logic          out_valid,
  input  logic          out_ready,
  output msk_pkg::key_t out_sorted_key,
  output logic          out_last_out,
  output logic          out_overflow
);
  import msk_pkg::*;

  localparam cnt_t FULL = CNT_W'(MAX_ITEMS);
  localparam cnt_t ONE  = CNT_W'(1);

  state_t    state_r, state_nxt;
  cnt_t      count_r, count_nxt;
  logic      dropped_r, dropped_nxt;
  logic      out_valid_r, out_valid_nxt;
  key_t      out_key_r, out_key_nxt;
  logic      out_last_r, out_last_nxt;
  logic      out_ovf_r, out_ovf_nxt;

  logic      in_xfer;
  logic      full;
  logic      pop;
  cell_cmd_t cmd;
  key_t      head_key;

  assign in_xfer = in_valid && in_ready;
  assign full    = count_r == FULL;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_xfer && in_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pop && count_r == ONE) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    pop      = 1'b0;
    case (state_r)
      ST_LOAD:  in_ready = 1'b1;
      ST_DRAIN: pop = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
        pop      = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd.ins = in_xfer && !full;
    cmd.shl = pop;
  end

  always_comb begin
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    if (cmd.ins) begin
      count_nxt = count_r + ONE;
    end else if (pop) begin
      count_nxt = count_r - ONE;
    end
    if (in_xfer && full) begin
      dropped_nxt = 1'b1;
    end else if (pop && count_r == ONE) begin
      dropped_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
      out_key_nxt   = head_key;
      out_last_nxt  = count_r == ONE;
      out_ovf_nxt   = dropped_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_key_r  <= out_key_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  msk_chain u_chain (
    .clk      (clk),
    .cmd      (cmd),
    .new_key  (in_key),
    .count    (count_r),
    .head_key (head_key)
  );

  assign out_valid      = out_valid_r;
  assign out_sorted_key = out_key_r;
  assign out_last_out   = out_last_r;
  assign out_overflow   = out_ovf_r;

  a_no_load_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> !in_ready)
    else $error("input ready while the set drains");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("key count above capacity");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && count_r == ONE) |=> (count_r == '0 && !dropped_r && out_last_r))
    else $error("final result shown while keys remain");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_last) |=> (state_r == ST_DRAIN && count_r != '0))
    else $error("set end did not start an emptying pass");

endmodule

### sim/merge_sort_keys_unit_tb.sv
// Self-checking testbench for merge_sort_keys_unit: loads key sets, predicts the sorted output.
// Depends on msk_pkg and the merge_sort_keys_unit RTL; needs no files or arguments.
module merge_sort_keys_unit_tb;
  import msk_pkg::*;

  localparam int CLK_HALF    = 2;
  localparam int IDLE_PCT    = 21;
  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 5000;
  localparam int TARGET_KEYS = 145;
  localparam int MAX_SHOWN   = 10;
  localparam int TAIL_CYCLES = 10;

  typedef struct packed {
    key_t key;
    logic last_out;
    logic ovf;
  } sorted_res_t;

  typedef struct packed {
    key_t        key;
    logic        last;
    logic        typed;
    sorted_res_t want;
  } stim_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  key_t in_key    = '0;
  logic in_last   = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  key_t out_sorted_key;
  logic out_last_out;
  logic out_overflow;

  // Keys of the set being loaded, in arrival order, and the drop mark.
  key_t        held_keys[$];
  logic        held_dropped = 1'b0;
  sorted_res_t batch_q[$];
  sorted_res_t sorted_due_q[$];

  int keys_sent     = 0;
  int sets_sent     = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int overflow_sets = 0;
  int quiet_cycles  = 0;

  logic calm      = 1'b0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;

  merge_sort_keys_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_key         (in_key),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sorted_key (out_sorted_key),
    .out_last_out   (out_last_out),
    .out_overflow   (out_overflow)
  );

  always #CLK_HALF clk = ~clk;

  // Stores one key and, on the final key of a set, emits the set in stable ascending order.
  function automatic void load_and_sort(input key_t k, input logic lst);
    key_t        ordered[$];
    int          pos;
    sorted_res_t r;
    if (held_keys.size() < MAX_ITEMS) begin
      held_keys.push_back(k);
    end else begin
      held_dropped = 1'b1;
    end
    if (!lst) return;
    foreach (held_keys[i]) begin
      pos = ordered.size();
      while (pos > 0 && ordered[pos-1] > held_keys[i]) pos--;
      ordered.insert(pos, held_keys[i]);
    end
    foreach (ordered[i]) begin
      r.key      = ordered[i];
      r.last_out = (i == ordered.size() - 1);
      r.ovf      = held_dropped;
      batch_q.push_back(r);
    end
    if (held_dropped) overflow_sets++;
    held_keys.delete();
    held_dropped = 1'b0;
  endfunction

  function automatic key_t draw_key();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return key_t'($urandom());
    // A narrow range gives plenty of equal keys.
    if (pick < 75) return key_t'($urandom_range(0, 3));
    if (pick < 85) return pick[0] ? {KEY_BITS{1'b1}} : '0;
    return {KEY_BITS{1'b1}} - key_t'($urandom_range(0, 15));
  endfunction

  // Called just after a falling edge; returns just after the falling edge
  // that follows the transfer.
  task automatic send_key(input key_t k, input logic lst, input logic typed,
                          input sorted_res_t want);
    logic took;
    took = 1'b0;
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < IDLE_PCT) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_key   <= k;
    in_last  <= lst;
    while (!took) begin
      @(posedge clk);
      took = in_ready;
      @(negedge clk);
    end
    keys_sent++;
    if (lst) sets_sent++;
    load_and_sort(k, lst);
    if (typed) begin
      batch_q.delete();
      sorted_due_q.push_back(want);
    end
    while (batch_q.size() > 0) sorted_due_q.push_back(batch_q.pop_front());
  endtask

  initial begin : rx_side
    int held;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        // Long hold-off so the chain fills and the input side stalls.
        out_ready <= 1'b0;
        for (held = 1; held < LONG_HOLD; held++) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : score
    sorted_res_t got;
    sorted_res_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_valid && out_ready) begin
        got.key      = out_sorted_key;
        got.last_out = out_last_out;
        got.ovf      = out_overflow;
        results_seen++;
        if (sorted_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("unexpected result transfer: key=%h last_out=%b overflow=%b",
                     got.key, got.last_out, got.ovf);
          end
        end else begin
          want = sorted_due_q.pop_front();
          if (got.key !== want.key || got.last_out !== want.last_out ||
              got.ovf !== want.ovf) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
              $display("result %0d: key exp=%h got=%h last_out exp=%b got=%b",
                       results_seen, want.key, got.key, want.last_out, got.last_out);
              $display("  overflow exp=%b got=%b", want.ovf, got.ovf);
            end
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results pending",
                 STALL_LIMIT, sorted_due_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stim
    stim_row_t rows[$];
    int        set_no;
    int        set_len;
    int        rand_keys;
    int        j;

    // Single-key sets carry their result in the row; the rest go through the predictor.
    rows.push_back({32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0});
    rows.push_back({32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0});
    rows.push_back({32'h0000_0005, 1'b0, 1'b0, 34'h0});
    rows.push_back({32'h0000_0003, 1'b0, 1'b0, 34'h0});
    rows.push_back({32'h0000_0005, 1'b0, 1'b0, 34'h0});
    rows.push_back({32'h0000_0001, 1'b1, 1'b0, 34'h0});
    rows.push_back({32'hFFFF_FFFF, 1'b0, 1'b0, 34'h0});
    rows.push_back({32'h0000_0000, 1'b0, 1'b0, 34'h0});
    rows.push_back({32'h8000_0000, 1'b0, 1'b0, 34'h0});
    rows.push_back({32'h7FFF_FFFF, 1'b1, 1'b0, 34'h0});
    rows.push_back({32'h5555_5555, 1'b0, 1'b0, 34'h0});
    rows.push_back({32'hAAAA_AAAA, 1'b1, 1'b0, 34'h0});
    rows.push_back({32'h0000_0000, 1'b0, 1'b0, 34'h0});
    rows.push_back({32'h0000_0000, 1'b1, 1'b0, 34'h0});
    rows.push_back({32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678, 1'b1, 1'b0});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_key(rows[i].key, rows[i].last, rows[i].typed, rows[i].want);

    // Let every directed result come out before the random phase starts.
    in_valid <= 1'b0;
    @(negedge clk);
    while (sorted_due_q.size() != 0) @(negedge clk);

    set_no    = 0;
    rand_keys = 0;
    while (rand_keys < TARGET_KEYS) begin
      if (set_no == 0) begin
        set_len = MAX_ITEMS;
        hold_req <= 1'b1;
      end else if (set_no == 1) begin
        // Three keys past capacity; the final key itself is dropped.
        set_len = MAX_ITEMS + 3;
      end else begin
        set_len = $urandom_range(1, 10);
      end
      // The over-capacity set and a few after it run with no idling on either side.
      calm <= (set_no >= 1 && set_no < 4);
      for (j = 0; j < set_len; j++) send_key(draw_key(), j == set_len - 1, 1'b0, '0);
      rand_keys += set_len;
      set_no++;
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (sorted_due_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d keys in %0d sets (%0d with dropped keys); checked %0d sorted results.",
             keys_sent, sets_sent, overflow_sets, results_seen);
    $display("Run included a %0d-cycle receiver hold-off and a full drain between phases.",
             LONG_HOLD);
    if (mismatches == 0 && sorted_due_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### merge_sort_keys_unit.f
rtl/core/msk_pkg.sv
rtl/core/msk_cell.sv
rtl/core/msk_chain.sv
rtl/core/merge_sort_keys_unit.sv
sim/merge_sort_keys_unit_tb.sv
